// File: hw/rtl/m6502pd_pkg.sv
package m6502pd_pkg;

    localparam logic [5:0] MN_ADC = 6'd0;
    localparam logic [5:0] MN_AND = 6'd1;
    localparam logic [5:0] MN_ASL = 6'd2;
    localparam logic [5:0] MN_BCC = 6'd3;
    localparam logic [5:0] MN_BCS = 6'd4;
    localparam logic [5:0] MN_BEQ = 6'd5;
    localparam logic [5:0] MN_BIT = 6'd6;
    localparam logic [5:0] MN_BMI = 6'd7;
    localparam logic [5:0] MN_BNE = 6'd8;
    localparam logic [5:0] MN_BPL = 6'd9;
    localparam logic [5:0] MN_BRK = 6'd10;
    localparam logic [5:0] MN_BVC = 6'd11;
    localparam logic [5:0] MN_BVS = 6'd12;
    localparam logic [5:0] MN_CLC = 6'd13;
    localparam logic [5:0] MN_CLD = 6'd14;
    localparam logic [5:0] MN_CLI = 6'd15;
    localparam logic [5:0] MN_CLV = 6'd16;
    localparam logic [5:0] MN_CMP = 6'd17;
    localparam logic [5:0] MN_CPX = 6'd18;
    localparam logic [5:0] MN_CPY = 6'd19;
    localparam logic [5:0] MN_DEC = 6'd20;
    localparam logic [5:0] MN_DEX = 6'd21;
    localparam logic [5:0] MN_DEY = 6'd22;
    localparam logic [5:0] MN_EOR = 6'd23;
    localparam logic [5:0] MN_INC = 6'd24;
    localparam logic [5:0] MN_INX = 6'd25;
    localparam logic [5:0] MN_INY = 6'd26;
    localparam logic [5:0] MN_JMP = 6'd27;
    localparam logic [5:0] MN_JSR = 6'd28;
    localparam logic [5:0] MN_LDA = 6'd29;
    localparam logic [5:0] MN_LDX = 6'd30;
    localparam logic [5:0] MN_LDY = 6'd31;
    localparam logic [5:0] MN_LSR = 6'd32;
    localparam logic [5:0] MN_NOP = 6'd33;
    localparam logic [5:0] MN_ORA = 6'd34;
    localparam logic [5:0] MN_PHA = 6'd35;
    localparam logic [5:0] MN_PHP = 6'd36;
    localparam logic [5:0] MN_PLA = 6'd37;
    localparam logic [5:0] MN_PLP = 6'd38;
    localparam logic [5:0] MN_ROL = 6'd39;
    localparam logic [5:0] MN_ROR = 6'd40;
    localparam logic [5:0] MN_RTI = 6'd41;
    localparam logic [5:0] MN_RTS = 6'd42;
    localparam logic [5:0] MN_SBC = 6'd43;
    localparam logic [5:0] MN_SEC = 6'd44;
    localparam logic [5:0] MN_SED = 6'd45;
    localparam logic [5:0] MN_SEI = 6'd46;
    localparam logic [5:0] MN_STA = 6'd47;
    localparam logic [5:0] MN_STX = 6'd48;
    localparam logic [5:0] MN_STY = 6'd49;
    localparam logic [5:0] MN_TAX = 6'd50;
    localparam logic [5:0] MN_TAY = 6'd51;
    localparam logic [5:0] MN_TSX = 6'd52;
    localparam logic [5:0] MN_TXA = 6'd53;
    localparam logic [5:0] MN_TXS = 6'd54;
    localparam logic [5:0] MN_TYA = 6'd55;
    localparam logic [5:0] MN_UND = 6'd56;

    localparam logic [3:0] MD_ACC = 4'd0;
    localparam logic [3:0] MD_IMP = 4'd1;
    localparam logic [3:0] MD_IMM = 4'd2;
    localparam logic [3:0] MD_REL = 4'd3;
    localparam logic [3:0] MD_ZP  = 4'd4;
    localparam logic [3:0] MD_ZPX = 4'd5;
    localparam logic [3:0] MD_ZPY = 4'd6;
    localparam logic [3:0] MD_IZX = 4'd7;
    localparam logic [3:0] MD_IZY = 4'd8;
    localparam logic [3:0] MD_ABS = 4'd9;
    localparam logic [3:0] MD_IND = 4'd10;
    localparam logic [3:0] MD_ABX = 4'd11;
    localparam logic [3:0] MD_ABY = 4'd12;

    localparam logic [7:0] OP_JMP_ABS = 8'h4c;
    localparam logic [7:0] OP_JMP_IND = 8'h6c;
    localparam logic [7:0] OP_JSR     = 8'h20;
    localparam logic [7:0] OP_RTI     = 8'h40;
    localparam logic [7:0] OP_RTS     = 8'h60;

    localparam logic [1:0] CNT_NONE = 2'd0;
    localparam logic [1:0] CNT_OP   = 2'd1;
    localparam logic [1:0] CNT_LOW  = 2'd2;

    localparam int STATE_DEPTH = 2;

    typedef struct packed {
        logic [5:0] mn;
        logic [3:0] md;
    } t_dec;

    typedef struct packed {
        logic [7:0]  op;
        logic [7:0]  low;
        logic [15:0] addr;
        logic [1:0]  cnt;
    } t_state;

    localparam int STATE_W = $bits(t_state);

    typedef struct packed {
        logic [15:0] instr_address;
        logic [7:0]  opcode_value;
        logic [5:0]  mnemonic_id;
        logic [3:0]  addr_mode;
        logic [1:0]  instr_length;
        logic [15:0] operand_value;
        logic        changes_flow;
        logic        is_undefined;
        logic        operand_is_address;
    } t_result;

    function automatic logic [1:0] f_length(input logic [3:0] md);
        logic [1:0] len;
        if (md <= MD_IMP) begin
            len = 2'd1;
        end else if (md <= MD_IZY) begin
            len = 2'd2;
        end else begin
            len = 2'd3;
        end
        return len;
    endfunction

    function automatic t_dec f_decode(input logic [7:0] op);
        t_dec d;
        case (op)
            8'h00: d = '{MN_BRK, MD_IMP};
            8'h01: d = '{MN_ORA, MD_IZX};
            8'h05: d = '{MN_ORA, MD_ZP};
            8'h06: d = '{MN_ASL, MD_ZP};
            8'h08: d = '{MN_PHP, MD_IMP};
            8'h09: d = '{MN_ORA, MD_IMM};
            8'h0a: d = '{MN_ASL, MD_ACC};
            8'h0d: d = '{MN_ORA, MD_ABS};
            8'h0e: d = '{MN_ASL, MD_ABS};
            8'h10: d = '{MN_BPL, MD_REL};
            8'h11: d = '{MN_ORA, MD_IZY};
            8'h15: d = '{MN_ORA, MD_ZPX};
            8'h16: d = '{MN_ASL, MD_ZPX};
            8'h18: d = '{MN_CLC, MD_IMP};
            8'h19: d = '{MN_ORA, MD_ABY};
            8'h1d: d = '{MN_ORA, MD_ABX};
            8'h1e: d = '{MN_ASL, MD_ABX};
            8'h20: d = '{MN_JSR, MD_ABS};
            8'h21: d = '{MN_AND, MD_IZX};
            8'h24: d = '{MN_BIT, MD_ZP};
            8'h25: d = '{MN_AND, MD_ZP};
            8'h26: d = '{MN_ROL, MD_ZP};
            8'h28: d = '{MN_PLP, MD_IMP};
            8'h29: d = '{MN_AND, MD_IMM};
            8'h2a: d = '{MN_ROL, MD_ACC};
            8'h2c: d = '{MN_BIT, MD_ABS};
            8'h2d: d = '{MN_AND, MD_ABS};
            8'h2e: d = '{MN_ROL, MD_ABS};
            8'h30: d = '{MN_BMI, MD_REL};
            8'h31: d = '{MN_AND, MD_IZY};
            8'h35: d = '{MN_AND, MD_ZPX};
            8'h36: d = '{MN_ROL, MD_ZPX};
            8'h38: d = '{MN_SEC, MD_IMP};
            8'h39: d = '{MN_AND, MD_ABY};
            8'h3d: d = '{MN_AND, MD_ABX};
            8'h3e: d = '{MN_ROL, MD_ABX};
            8'h40: d = '{MN_RTI, MD_IMP};
            8'h41: d = '{MN_EOR, MD_IZX};
            8'h45: d = '{MN_EOR, MD_ZP};
            8'h46: d = '{MN_LSR, MD_ZP};
            8'h48: d = '{MN_PHA, MD_IMP};
            8'h49: d = '{MN_EOR, MD_IMM};
            8'h4a: d = '{MN_LSR, MD_ACC};
            8'h4c: d = '{MN_JMP, MD_ABS};
            8'h4d: d = '{MN_EOR, MD_ABS};
            8'h4e: d = '{MN_LSR, MD_ABS};
            8'h50: d = '{MN_BVC, MD_REL};
            8'h51: d = '{MN_EOR, MD_IZY};
            8'h55: d = '{MN_EOR, MD_ZPX};
            8'h56: d = '{MN_LSR, MD_ZPX};
            8'h58: d = '{MN_CLI, MD_IMP};
            8'h59: d = '{MN_EOR, MD_ABY};
            8'h5d: d = '{MN_EOR, MD_ABX};
            8'h5e: d = '{MN_LSR, MD_ABX};
            8'h60: d = '{MN_RTS, MD_IMP};
            8'h61: d = '{MN_ADC, MD_IZX};
            8'h65: d = '{MN_ADC, MD_ZP};
            8'h66: d = '{MN_ROR, MD_ZP};
            8'h68: d = '{MN_PLA, MD_IMP};
            8'h69: d = '{MN_ADC, MD_IMM};
            8'h6a: d = '{MN_ROR, MD_ACC};
            8'h6c: d = '{MN_JMP, MD_IND};
            8'h6d: d = '{MN_ADC, MD_ABS};
            8'h6e: d = '{MN_ROR, MD_ABS};
            8'h70: d = '{MN_BVS, MD_REL};
            8'h71: d = '{MN_ADC, MD_IZY};
            8'h75: d = '{MN_ADC, MD_ZPX};
            8'h76: d = '{MN_ROR, MD_ZPX};
            8'h78: d = '{MN_SEI, MD_IMP};
            8'h79: d = '{MN_ADC, MD_ABY};
            8'h7d: d = '{MN_ADC, MD_ABX};
            8'h7e: d = '{MN_ROR, MD_ABX};
            8'h81: d = '{MN_STA, MD_IZX};
            8'h84: d = '{MN_STY, MD_ZP};
            8'h85: d = '{MN_STA, MD_ZP};
            8'h86: d = '{MN_STX, MD_ZP};
            8'h88: d = '{MN_DEY, MD_IMP};
            8'h8a: d = '{MN_TXA, MD_IMP};
            8'h8c: d = '{MN_STY, MD_ABS};
            8'h8d: d = '{MN_STA, MD_ABS};
            8'h8e: d = '{MN_STX, MD_ABS};
            8'h90: d = '{MN_BCC, MD_REL};
            8'h91: d = '{MN_STA, MD_IZY};
            8'h94: d = '{MN_STY, MD_ZPX};
            8'h95: d = '{MN_STA, MD_ZPX};
            8'h96: d = '{MN_STX, MD_ZPY};
            8'h98: d = '{MN_TYA, MD_IMP};
            8'h99: d = '{MN_STA, MD_ABY};
            8'h9a: d = '{MN_TXS, MD_IMP};
            8'h9d: d = '{MN_STA, MD_ABX};
            8'ha0: d = '{MN_LDY, MD_IMM};
            8'ha1: d = '{MN_LDA, MD_IZX};
            8'ha2: d = '{MN_LDX, MD_IMM};
            8'ha4: d = '{MN_LDY, MD_ZP};
            8'ha5: d = '{MN_LDA, MD_ZP};
            8'ha6: d = '{MN_LDX, MD_ZP};
            8'ha8: d = '{MN_TAY, MD_IMP};
            8'ha9: d = '{MN_LDA, MD_IMM};
            8'haa: d = '{MN_TAX, MD_IMP};
            8'hac: d = '{MN_LDY, MD_ABS};
            8'had: d = '{MN_LDA, MD_ABS};
            8'hae: d = '{MN_LDX, MD_ABS};
            8'hb0: d = '{MN_BCS, MD_REL};
            8'hb1: d = '{MN_LDA, MD_IZY};
            8'hb4: d = '{MN_LDY, MD_ZPX};
            8'hb5: d = '{MN_LDA, MD_ZPX};
            8'hb6: d = '{MN_LDX, MD_ZPY};
            8'hb8: d = '{MN_CLV, MD_IMP};
            8'hb9: d = '{MN_LDA, MD_ABY};
            8'hba: d = '{MN_TSX, MD_IMP};
            8'hbc: d = '{MN_LDY, MD_ABX};
            8'hbd: d = '{MN_LDA, MD_ABX};
            8'hbe: d = '{MN_LDX, MD_ABY};
            8'hc0: d = '{MN_CPY, MD_IMM};
            8'hc1: d = '{MN_CMP, MD_IZX};
            8'hc4: d = '{MN_CPY, MD_ZP};
            8'hc5: d = '{MN_CMP, MD_ZP};
            8'hc6: d = '{MN_DEC, MD_ZP};
            8'hc8: d = '{MN_INY, MD_IMP};
            8'hc9: d = '{MN_CMP, MD_IMM};
            8'hca: d = '{MN_DEX, MD_IMP};
            8'hcc: d = '{MN_CPY, MD_ABS};
            8'hcd: d = '{MN_CMP, MD_ABS};
            8'hce: d = '{MN_DEC, MD_ABS};
            8'hd0: d = '{MN_BNE, MD_REL};
            8'hd1: d = '{MN_CMP, MD_IZY};
            8'hd5: d = '{MN_CMP, MD_ZPX};
            8'hd6: d = '{MN_DEC, MD_ZPX};
            8'hd8: d = '{MN_CLD, MD_IMP};
            8'hd9: d = '{MN_CMP, MD_ABY};
            8'hdd: d = '{MN_CMP, MD_ABX};
            8'hde: d = '{MN_DEC, MD_ABX};
            8'he0: d = '{MN_CPX, MD_IMM};
            8'he1: d = '{MN_SBC, MD_IZX};
            8'he4: d = '{MN_CPX, MD_ZP};
            8'he5: d = '{MN_SBC, MD_ZP};
            8'he6: d = '{MN_INC, MD_ZP};
            8'he8: d = '{MN_INX, MD_IMP};
            8'he9: d = '{MN_SBC, MD_IMM};
            8'hea: d = '{MN_NOP, MD_IMP};
            8'hec: d = '{MN_CPX, MD_ABS};
            8'hed: d = '{MN_SBC, MD_ABS};
            8'hee: d = '{MN_INC, MD_ABS};
            8'hf0: d = '{MN_BEQ, MD_REL};
            8'hf1: d = '{MN_SBC, MD_IZY};
            8'hf5: d = '{MN_SBC, MD_ZPX};
            8'hf6: d = '{MN_INC, MD_ZPX};
            8'hf8: d = '{MN_SED, MD_IMP};
            8'hf9: d = '{MN_SBC, MD_ABY};
            8'hfd: d = '{MN_SBC, MD_ABX};
            8'hfe: d = '{MN_INC, MD_ABX};
            default: d = '{MN_UND, MD_IMP};
        endcase
        return d;
    endfunction

endpackage

// File: hw/rtl/m6502pd_ram.sv
module m6502pd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: hw/rtl/m6502pd_emit.sv
module m6502pd_emit (
    input  logic [7:0]          i_opcode,
    input  logic [15:0]         i_address,
    input  logic [15:0]         i_operand,
    output m6502pd_pkg::t_result o_result
);

    import m6502pd_pkg::*;

    t_dec        dec;
    logic [1:0]  len;
    logic [15:0] target;

    always_comb begin
        dec    = f_decode(i_opcode);
        len    = f_length(dec.md);
        target = i_address + 16'd2 + {{8{i_operand[7]}}, i_operand[7:0]};

        o_result.instr_address = i_address;
        o_result.opcode_value  = i_opcode;
        o_result.mnemonic_id   = dec.mn;
        o_result.addr_mode     = dec.md;
        o_result.instr_length  = len;
        if (dec.md == MD_REL) begin
            o_result.operand_value = target;
        end else if (len == 2'd1) begin
            o_result.operand_value = 16'd0;
        end else begin
            o_result.operand_value = i_operand;
        end
        o_result.changes_flow = (dec.md == MD_REL) ||
            (i_opcode inside {OP_JMP_ABS, OP_JMP_IND, OP_JSR, OP_RTI, OP_RTS});
        o_result.is_undefined       = (dec.mn == MN_UND);
        o_result.operand_is_address = (dec.md >= MD_REL);
    end

endmodule

// File: hw/rtl/mos6502_instruction_predecoder.sv
// NMOS 6502 instruction predecoder.
// Input channel (i_valid / o_ready): one code byte per request with its
// address and a restart flag; restart makes the byte an opcode and drops a
// partly assembled instruction without a result.
// Output channel (o_valid / i_ready): one request per completed instruction
// carrying the opcode address, opcode, mnemonic, addressing mode, length,
// operand (branch target for relative mode) and three flags.
// Throughput is one code byte per cycle while the output is not stalled.
// The assembly state lives in a small synchronous RAM; it is read when a
// byte is accepted and written back when that byte leaves the working
// stage, with the value just written forwarded when the next byte follows
// directly. A result is registered when its last byte leaves that stage.
// Reset clears all control state; the state RAM is treated as empty until
// its first write, so the first byte is taken as an opcode.
// When the receiver stalls, the finished result waits in the output
// register, one more byte is taken into the working stage, and then
// o_ready drops until the output is taken.
module mos6502_instruction_predecoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_code_byte,
    input  logic [15:0] i_byte_address,
    input  logic        i_restart,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [15:0] o_instr_address,
    output logic [7:0]  o_opcode_value,
    output logic [5:0]  o_mnemonic_id,
    output logic [3:0]  o_addr_mode,
    output logic [1:0]  o_instr_length,
    output logic [15:0] o_operand_value,
    output logic        o_changes_flow,
    output logic        o_is_undefined,
    output logic        o_operand_is_address
);

    import m6502pd_pkg::*;

    localparam logic [$clog2(STATE_DEPTH)-1:0] STATE_ENTRY = '0;

    logic               in_fire;
    logic               s1_fire;
    logic               r_s1_valid;
    logic [7:0]         r_s1_byte;
    logic [15:0]        r_s1_addr;
    logic               r_s1_restart;
    logic               r_fwd_sel;
    t_state             r_fwd;
    logic               r_st_valid;
    logic [STATE_W-1:0] rd_data;
    t_state             st;
    t_state             n_state;
    logic               new_instr;
    logic               emit_en;
    logic [7:0]         em_op;
    logic [15:0]        em_addr;
    logic [15:0]        em_operand;
    t_result            em_result;
    logic               r_out_valid;
    t_result            r_out;

    assign s1_fire = r_s1_valid && (!r_out_valid || i_ready);
    assign o_ready = !r_s1_valid || s1_fire;
    assign in_fire = i_valid && o_ready;

    m6502pd_ram #(
        .WIDTH (STATE_W),
        .DEPTH (STATE_DEPTH)
    ) u_state_ram (
        .i_clk     (i_clk),
        .i_wr_en   (s1_fire),
        .i_wr_addr (STATE_ENTRY),
        .i_wr_data (n_state),
        .i_rd_en   (in_fire),
        .i_rd_addr (STATE_ENTRY),
        .o_rd_data (rd_data)
    );

    always_comb begin
        if (r_fwd_sel) begin
            st = r_fwd;
        end else if (r_st_valid) begin
            st = t_state'(rd_data);
        end else begin
            st = '0;
        end

        new_instr  = r_s1_restart || st.cnt == CNT_NONE || st.cnt > CNT_LOW;
        n_state    = st;
        emit_en    = 1'b0;
        em_op      = st.op;
        em_addr    = st.addr;
        em_operand = 16'd0;

        if (new_instr) begin
            if (f_length(f_decode(r_s1_byte).md) == 2'd1) begin
                n_state.cnt = CNT_NONE;
                emit_en     = 1'b1;
                em_op       = r_s1_byte;
                em_addr     = r_s1_addr;
            end else begin
                n_state.op   = r_s1_byte;
                n_state.addr = r_s1_addr;
                n_state.cnt  = CNT_OP;
            end
        end else if (st.cnt == CNT_OP) begin
            if (f_length(f_decode(st.op).md) == 2'd2) begin
                n_state.cnt = CNT_NONE;
                emit_en     = 1'b1;
                em_operand  = {8'd0, r_s1_byte};
            end else begin
                n_state.low = r_s1_byte;
                n_state.cnt = CNT_LOW;
            end
        end else begin
            n_state.cnt = CNT_NONE;
            emit_en     = 1'b1;
            em_operand  = {r_s1_byte, st.low};
        end
    end

    m6502pd_emit u_emit (
        .i_opcode  (em_op),
        .i_address (em_addr),
        .i_operand (em_operand),
        .o_result  (em_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_fwd_sel   <= 1'b0;
            r_st_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_fire) begin
                r_s1_valid <= 1'b1;
                r_fwd_sel  <= s1_fire;
            end else if (s1_fire) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_fire) begin
                r_st_valid <= 1'b1;
            end
            if (s1_fire && emit_en) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1_byte    <= i_code_byte;
            r_s1_addr    <= i_byte_address;
            r_s1_restart <= i_restart;
        end
        if (s1_fire) begin
            r_fwd <= n_state;
        end
        if (s1_fire && emit_en) begin
            r_out <= em_result;
        end
    end

    assign o_valid              = r_out_valid;
    assign o_instr_address      = r_out.instr_address;
    assign o_opcode_value       = r_out.opcode_value;
    assign o_mnemonic_id        = r_out.mnemonic_id;
    assign o_addr_mode          = r_out.addr_mode;
    assign o_instr_length       = r_out.instr_length;
    assign o_operand_value      = r_out.operand_value;
    assign o_changes_flow       = r_out.changes_flow;
    assign o_is_undefined       = r_out.is_undefined;
    assign o_operand_is_address = r_out.operand_is_address;

`ifndef SYNTHESIS
    a_stage_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && r_out_valid && !i_ready |=> r_s1_valid)
        else $error("working stage lost a byte while the output was stalled");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_fire |-> n_state.cnt <= CNT_LOW)
        else $error("assembly count written out of range");

    a_forward_sel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire && s1_fire |=> r_fwd_sel)
        else $error("state forwarding not selected after a concurrent write");

    a_short_operand: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && o_instr_length == 2'd1 |-> o_operand_value == 16'd0)
        else $error("one-byte instruction carries an operand");
`endif

endmodule
